// ===== rtl/mfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// shared types and constants for the motion-capture frame deframer
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int unsigned MaxBodiesDefault = 128;
    localparam logic [15:0] MsgFrame         = 16'd7;

    localparam logic [4:0] TagFrame    = 5'd0;
    localparam logic [4:0] TagId       = 5'd1;
    localparam logic [4:0] TagX        = 5'd2;
    localparam logic [4:0] TagY        = 5'd3;
    localparam logic [4:0] TagZ        = 5'd4;
    localparam logic [4:0] TagQx       = 5'd5;
    localparam logic [4:0] TagQy       = 5'd6;
    localparam logic [4:0] TagQz       = 5'd7;
    localparam logic [4:0] TagQw       = 5'd8;
    localparam logic [4:0] TagErr      = 5'd9;
    localparam logic [4:0] TagLat      = 5'd10;
    localparam logic [4:0] TagTc       = 5'd11;
    localparam logic [4:0] TagTcs      = 5'd12;
    localparam logic [4:0] TagTs       = 5'd13;
    localparam logic [4:0] TagFlags    = 5'd14;
    localparam logic [4:0] TagEod      = 5'd15;
    localparam logic [4:0] TagOverflow = 5'd16;

    localparam logic CfgMajor = 1'b0;
    localparam logic CfgMinor = 1'b1;

    typedef enum logic [5:0] {
        S_MSGID, S_NBYTES, S_IDLE, S_FRAME, S_NMSETS, S_MSNAME, S_MSNMARK,
        S_NOTHER, S_NBODIES, S_BID, S_B1, S_B2, S_B3, S_Q1, S_Q2, S_Q3, S_Q4,
        S_BNMARK, S_BERR, S_BPARAM, S_NSKEL, S_SKID, S_SKNB, S_BONENMARK,
        S_BONEERR, S_BONEPARAM, S_NLAB, S_NFP, S_FPID, S_FPNCH, S_FPNFR,
        S_LAT, S_TC, S_TCS, S_TS, S_FLAGS, S_EOD, S_SKIP,
        P_MSET, P_BODY, P_LAB, P_CHAN
    } sect_t;

    function automatic logic [4:0] body_tag(input logic [2:0] idx);
        logic [4:0] t;
        case (idx)
            3'd0:    t = TagId;
            3'd1:    t = TagY;
            3'd2:    t = TagZ;
            3'd3:    t = TagX;
            3'd4:    t = TagQx;
            3'd5:    t = TagQz;
            3'd6:    t = TagQy;
            default: t = TagQw;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/mocap_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mocap_frame_deframer_unit
// byte-serial frame-of-data parser emitting tagged words
// ----------------------------------------------------------------------------
// One packet byte is taken per clock while in_ready is high. The section
// state machine advances once per byte and a finished word leaves through a
// one-entry output register the cycle after its last byte; in_ready stays
// high while that register is free or being drained, so a full stream runs at
// one beat per cycle. Skipped regions are counted down one byte per beat with
// a 38-bit counter. A version write takes effect at the next section decision.
module mocap_frame_deframer_unit
    import mfd_pkg::*;
#(
    parameter int unsigned MAX_BODIES = MaxBodiesDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        packet_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  field_tag,
    output logic [6:0]  body_slot,
    output logic [63:0] field_value,
    output logic        frame_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CntW = $clog2(MAX_BODIES + 1) + 1;

    logic [7:0]  major_reg, minor_reg;
    sect_t       state_reg, state_next;
    logic [63:0] shift_reg, shift_next;
    logic [3:0]  biw_reg, biw_next;
    logic [15:0] msgid_reg, msgid_next;
    logic [31:0] outer_reg, outer_next, middle_reg, middle_next;
    logic [CntW-1:0] cur_reg, cur_next, total_reg, total_next;
    logic [37:0] skip_reg, skip_next;
    sect_t       after_reg, after_next;

    logic        ov_reg;
    logic [4:0]  tag_reg;
    logic [6:0]  slot_reg;
    logic [63:0] val_reg;
    logic        done_reg;

    logic        em;
    logic [4:0]  em_tag;
    logic [6:0]  em_slot;
    logic        em_done;
    logic [63:0] em_val;

    logic accept;

    assign cfg_ready   = 1'b1;
    assign in_ready    = !ov_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign out_valid   = ov_reg;
    assign field_tag   = tag_reg;
    assign body_slot   = slot_reg;
    assign field_value = val_reg;
    assign frame_done  = done_reg;

    function automatic logic v_at(input logic [7:0] mj, input logic [7:0] mn,
                                  input logic [7:0] m);
        return (mj == 8'd2 && mn >= m) || mj > 8'd2;
    endfunction

    always_comb
    begin
        logic        ge2, par;
        logic [3:0]  wlen;
        logic [63:0] w;
        logic [3:0]  nb;
        logic [31:0] n;
        sect_t       s, tgt;
        logic        skip_go;
        logic [37:0] skip_n;
        logic        do_enter;
        logic [CntW-1:0] cinc;

        state_next  = state_reg;
        shift_next  = shift_reg;
        biw_next    = biw_reg;
        msgid_next  = msgid_reg;
        outer_next  = outer_reg;
        middle_next = middle_reg;
        cur_next    = cur_reg;
        total_next  = total_reg;
        skip_next   = skip_reg;
        after_next  = after_reg;
        em = 1'b0; em_tag = TagFrame; em_slot = 7'd0; em_done = 1'b0;
        em_val = 64'd0;
        ge2 = major_reg >= 8'd2;
        par = v_at(major_reg, minor_reg, 8'd6) || major_reg == 8'd0;
        skip_go = 1'b0; skip_n = 38'd0; do_enter = 1'b0; tgt = S_IDLE;
        cinc = cur_reg + 1'b1;

        s = state_reg;
        if (packet_start)
        begin
            s = S_MSGID;
            shift_next = 64'd0; biw_next = 4'd0; msgid_next = 16'd0;
            outer_next = 32'd0; middle_next = 32'd0; cur_next = '0;
            total_next = '0; skip_next = 38'd0; after_next = S_MSGID;
        end
        state_next = s;

        case (s)
            S_MSGID, S_NBYTES, S_BPARAM, S_BONEPARAM, S_FLAGS: wlen = 4'd2;
            S_TS:    wlen = v_at(major_reg, minor_reg, 8'd7) ? 4'd8 : 4'd4;
            default: wlen = 4'd4;
        endcase
        w  = shift_next | ({56'd0, data_byte} << {biw_next[2:0], 3'b000});
        nb = biw_next + 4'd1;
        n  = w[31] ? 32'd0 : w[31:0];

        if (s == S_IDLE)
        begin
        end
        else if (s == S_SKIP)
        begin
            skip_next = skip_reg - 38'd1;
            if (skip_reg == 38'd1)
            begin
                if (after_reg inside {P_MSET, P_BODY, P_LAB, P_CHAN})
                begin
                    do_enter = 1'b1; tgt = after_reg;
                end
                else state_next = after_reg;
            end
        end
        else if (s == S_MSNAME)
        begin
            if (data_byte == 8'd0)
            begin
                state_next = S_MSNMARK; shift_next = '0; biw_next = '0;
            end
        end
        else
        begin
            shift_next = w; biw_next = nb;
            if (nb >= wlen)
            begin
                shift_next = '0; biw_next = '0;
                case (s)
                    S_MSGID:
                    begin
                        msgid_next = w[15:0]; state_next = S_NBYTES;
                    end
                    S_NBYTES: state_next = (msgid_reg == MsgFrame) ? S_FRAME : S_IDLE;
                    S_FRAME:
                    begin
                        em = 1'b1; em_tag = TagFrame; em_val = w; state_next = S_NMSETS;
                    end
                    S_NMSETS:
                    begin
                        outer_next = n; do_enter = 1'b1; tgt = P_MSET;
                    end
                    S_MSNMARK:
                    begin
                        skip_go = 1'b1; skip_n = 38'(n) * 38'd12; tgt = P_MSET;
                    end
                    S_NOTHER:
                    begin
                        skip_go = 1'b1; skip_n = 38'(n) * 38'd12; tgt = S_NBODIES;
                    end
                    S_NBODIES:
                    begin
                        if (n > 32'(MAX_BODIES))
                        begin
                            em = 1'b1; em_tag = TagOverflow; em_val = w;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            total_next = n[CntW-1:0]; cur_next = '0;
                            if (n != 32'd0) state_next = S_BID;
                            else if (v_at(major_reg, minor_reg, 8'd1)) state_next = S_NSKEL;
                            else
                            begin
                                do_enter = 1'b1; tgt = S_NSKEL;
                            end
                        end
                    end
                    S_BID, S_B1, S_B2, S_B3, S_Q1, S_Q2, S_Q3, S_Q4:
                    begin
                        em = 1'b1; em_tag = body_tag(3'(s - S_BID));
                        em_slot = cur_reg[6:0]; em_val = w;
                        state_next = sect_t'(s + 6'd1);
                    end
                    S_BNMARK:
                    begin
                        skip_go = 1'b1;
                        skip_n = 38'(n) * (ge2 ? 38'd20 : 38'd12);
                        tgt = ge2 ? S_BERR : (par ? S_BPARAM : P_BODY);
                    end
                    S_BERR:
                    begin
                        em = 1'b1; em_tag = TagErr; em_slot = cur_reg[6:0]; em_val = w;
                        if (par) state_next = S_BPARAM;
                        else
                        begin
                            do_enter = 1'b1; tgt = P_BODY;
                        end
                    end
                    S_BPARAM:
                    begin
                        do_enter = 1'b1; tgt = P_BODY;
                    end
                    S_NSKEL:
                    begin
                        outer_next = n; do_enter = 1'b1; tgt = S_SKID;
                    end
                    S_SKID: state_next = S_SKNB;
                    S_SKNB:
                    begin
                        middle_next = n; do_enter = 1'b1; tgt = S_BONENMARK;
                    end
                    S_BONENMARK:
                    begin
                        skip_go = 1'b1; skip_n = 38'(n) * 38'd20; tgt = S_BONEERR;
                    end
                    S_BONEERR:
                    begin
                        if (par) state_next = S_BONEPARAM;
                        else
                        begin
                            do_enter = 1'b1; tgt = S_BONENMARK;
                        end
                    end
                    S_BONEPARAM:
                    begin
                        do_enter = 1'b1; tgt = S_BONENMARK;
                    end
                    S_NLAB:
                    begin
                        skip_go = 1'b1; skip_n = 38'(n) * (par ? 38'd22 : 38'd20);
                        tgt = P_LAB;
                    end
                    S_NFP:
                    begin
                        outer_next = n; do_enter = 1'b1; tgt = S_FPID;
                    end
                    S_FPID: state_next = S_FPNCH;
                    S_FPNCH:
                    begin
                        middle_next = n; do_enter = 1'b1; tgt = P_CHAN;
                    end
                    S_FPNFR:
                    begin
                        skip_go = 1'b1; skip_n = 38'(n) * 38'd4; tgt = P_CHAN;
                    end
                    S_LAT:
                    begin
                        em = 1'b1; em_tag = TagLat; em_val = w; state_next = S_TC;
                    end
                    S_TC:
                    begin
                        em = 1'b1; em_tag = TagTc; em_val = w; state_next = S_TCS;
                    end
                    S_TCS:
                    begin
                        em = 1'b1; em_tag = TagTcs; em_val = w; state_next = S_TS;
                    end
                    S_TS:
                    begin
                        em = 1'b1; em_tag = TagTs; em_val = w; state_next = S_FLAGS;
                    end
                    S_FLAGS:
                    begin
                        em = 1'b1; em_tag = TagFlags; em_val = w; state_next = S_EOD;
                    end
                    S_EOD:
                    begin
                        em = 1'b1; em_tag = TagEod; em_val = w; em_done = 1'b1;
                        state_next = S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
        end

        if (skip_go)
        begin
            if (skip_n == 38'd0) do_enter = 1'b1;
            else
            begin
                state_next = S_SKIP; skip_next = skip_n; after_next = tgt;
            end
        end

        // section continuations; the "x" states here double as loop heads
        if (do_enter)
        begin
            shift_next = '0; biw_next = '0;
            case (tgt)
                P_MSET:
                begin
                    if (outer_next != 32'd0)
                    begin
                        outer_next = outer_next - 32'd1; state_next = S_MSNAME;
                    end
                    else state_next = S_NOTHER;
                end
                P_BODY:
                begin
                    cur_next = cinc;
                    if (cinc < total_next) state_next = S_BID;
                    else if (v_at(major_reg, minor_reg, 8'd1)) state_next = S_NSKEL;
                    else if (v_at(major_reg, minor_reg, 8'd3)) state_next = S_NLAB;
                    else state_next = v_at(major_reg, minor_reg, 8'd9) ? S_NFP : S_LAT;
                end
                S_NSKEL:
                begin
                    if (v_at(major_reg, minor_reg, 8'd3)) state_next = S_NLAB;
                    else state_next = v_at(major_reg, minor_reg, 8'd9) ? S_NFP : S_LAT;
                end
                S_SKID:
                begin
                    if (outer_next != 32'd0)
                    begin
                        outer_next = outer_next - 32'd1; state_next = S_SKID;
                    end
                    else if (v_at(major_reg, minor_reg, 8'd3)) state_next = S_NLAB;
                    else state_next = v_at(major_reg, minor_reg, 8'd9) ? S_NFP : S_LAT;
                end
                S_BONENMARK:
                begin
                    if (middle_next != 32'd0)
                    begin
                        middle_next = middle_next - 32'd1;
                        state_next = S_SKIP; skip_next = 38'd32; after_next = S_BONENMARK;
                    end
                    else if (outer_next != 32'd0)
                    begin
                        outer_next = outer_next - 32'd1; state_next = S_SKID;
                    end
                    else if (v_at(major_reg, minor_reg, 8'd3)) state_next = S_NLAB;
                    else state_next = v_at(major_reg, minor_reg, 8'd9) ? S_NFP : S_LAT;
                end
                P_LAB:
                    state_next = v_at(major_reg, minor_reg, 8'd9) ? S_NFP : S_LAT;
                S_FPID:
                begin
                    if (outer_next != 32'd0)
                    begin
                        outer_next = outer_next - 32'd1; state_next = S_FPID;
                    end
                    else state_next = S_LAT;
                end
                P_CHAN:
                begin
                    if (middle_next != 32'd0)
                    begin
                        middle_next = middle_next - 32'd1; state_next = S_FPNFR;
                    end
                    else if (outer_next != 32'd0)
                    begin
                        outer_next = outer_next - 32'd1; state_next = S_FPID;
                    end
                    else state_next = S_LAT;
                end
                default: state_next = tgt;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg <= 8'd2;
            minor_reg <= 8'd9;
            state_reg <= S_MSGID;
            shift_reg <= '0;
            biw_reg   <= '0;
            msgid_reg <= '0;
            outer_reg <= '0;
            middle_reg <= '0;
            cur_reg   <= '0;
            total_reg <= '0;
            skip_reg  <= '0;
            after_reg <= S_MSGID;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CfgMajor) major_reg <= cfg_data;
                if (cfg_index == CfgMinor) minor_reg <= cfg_data;
            end
            if (accept)
            begin
                state_reg  <= state_next;
                shift_reg  <= shift_next;
                biw_reg    <= biw_next;
                msgid_reg  <= msgid_next;
                outer_reg  <= outer_next;
                middle_reg <= middle_next;
                cur_reg    <= cur_next;
                total_reg  <= total_next;
                skip_reg   <= skip_next;
                after_reg  <= after_next;
            end
            if (accept && em) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && em)
        begin
            tag_reg  <= em_tag;
            slot_reg <= em_slot;
            val_reg  <= em_val;
            done_reg <= em_done;
        end
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(field_value))
        else $error("result dropped while stalled");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_done == (field_tag == TagEod)))
        else $error("frame_done mismatch");
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (field_tag == TagFrame || field_tag > TagErr) |-> body_slot == 7'd0)
        else $error("slot on non-body field");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
`endif

endmodule
